[design/goh_pkg.sv]
// ----------------------------------------------------------------------------
// Gradient orientation histogram package
// Shared op codes, phase constants, the CORDIC arctangent table and the
// request and result structs between the top level and the polar unit.
// ----------------------------------------------------------------------------
`default_nettype none

package goh_pkg;

    // Item kinds on the input channel, echoed on the result channel.
    localparam logic [1:0] OP_ACCUM = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Phase is a 32-bit fraction of a full turn.
    localparam logic [31:0] PHASE_OCTANT  = 32'h2000_0000;
    localparam logic [31:0] PHASE_QUARTER = 32'h4000_0000;
    localparam logic [31:0] PHASE_HALF    = 32'h8000_0000;

    localparam int CORDIC_STEPS    = 30;
    localparam int CORDIC_PRESHIFT = 24;

    // Widths of the result fields.
    localparam int MAG_W = 11;
    localparam int SUM_W = 40;

    // atan(2^-i) in phase units, rounded.
    function automatic logic [31:0] atan_phase(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'd536870912;
            5'd1:    val = 32'd316933406;
            5'd2:    val = 32'd167458907;
            5'd3:    val = 32'd85004756;
            5'd4:    val = 32'd42667331;
            5'd5:    val = 32'd21354465;
            5'd6:    val = 32'd10680094;
            5'd7:    val = 32'd5340245;
            5'd8:    val = 32'd2670163;
            5'd9:    val = 32'd1335087;
            5'd10:   val = 32'd667544;
            5'd11:   val = 32'd333772;
            5'd12:   val = 32'd166886;
            5'd13:   val = 32'd83443;
            5'd14:   val = 32'd41722;
            5'd15:   val = 32'd20861;
            5'd16:   val = 32'd10430;
            5'd17:   val = 32'd5215;
            5'd18:   val = 32'd2608;
            5'd19:   val = 32'd1304;
            5'd20:   val = 32'd652;
            5'd21:   val = 32'd326;
            5'd22:   val = 32'd163;
            5'd23:   val = 32'd81;
            5'd24:   val = 32'd41;
            5'd25:   val = 32'd20;
            5'd26:   val = 32'd10;
            5'd27:   val = 32'd5;
            5'd28:   val = 32'd3;
            5'd29:   val = 32'd1;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

    // Start of a polar conversion.
    typedef struct packed {
        logic              start;
        logic signed [8:0] grad_x;
        logic signed [8:0] grad_y;
    } polar_req_t;

    // Finished polar conversion, valid while done is high.
    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] magnitude;
        logic [31:0]      phase;
    } polar_res_t;

endpackage

`default_nettype wire

[design/goh_polar.sv]
// ----------------------------------------------------------------------------
// Gradient polar converter
// Iterative unit that turns one gradient into a rounded magnitude in quarter
// units (integer square root, two bits per step) and a 32-bit phase (CORDIC
// vectoring, one step per cycle), sharing a single step counter.
// ----------------------------------------------------------------------------
`default_nettype none

module goh_polar (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire goh_pkg::polar_req_t req,
    output      goh_pkg::polar_res_t res
);

    typedef enum logic [1:0] {
        P_IDLE,
        P_SQUARE,
        P_ITER,
        P_FINAL
    } pstate_t;

    pstate_t            state_reg, state_next;
    logic [4:0]         step_reg, step_next;
    logic               gxn_reg, gxn_next;
    logic               gyn_reg, gyn_next;
    logic               swap_reg, swap_next;
    logic               zero_reg, zero_next;
    logic               diag_reg, diag_next;
    logic [8:0]         ay_reg, ay_next;
    logic [17:0]        sq_reg, sq_next;
    logic signed [35:0] x_reg, x_next;
    logic signed [35:0] y_reg, y_next;
    logic signed [31:0] z_reg, z_next;
    logic [22:0]        rem_reg, rem_next;
    logic [22:0]        root_reg, root_next;
    logic [22:0]        bit_reg, bit_next;
    logic               done_reg, done_next;
    logic [goh_pkg::MAG_W-1:0] mag_reg, mag_next;
    logic [31:0]        phase_reg, phase_next;

    logic [8:0]         ax_in, ay_in, s_in, l_in;
    logic               swap_in;
    logic [17:0]        ax_sq, ay_sq, sum_sq;
    logic signed [35:0] dx, dy;
    logic [31:0]        atan_val;
    logic [23:0]        trial;
    logic [31:0]        oct, quad, phase_calc;

    // Absolute values and octant fold of the incoming gradient.
    assign ax_in   = req.grad_x[8] ? (~req.grad_x + 9'd1) : req.grad_x;
    assign ay_in   = req.grad_y[8] ? (~req.grad_y + 9'd1) : req.grad_y;
    assign swap_in = ay_in > ax_in;
    assign s_in    = swap_in ? ax_in : ay_in;
    assign l_in    = swap_in ? ay_in : ax_in;

    // One squaring multiplier per setup cycle.
    assign ax_sq  = {9'd0, ax_in} * {9'd0, ax_in};
    assign ay_sq  = {9'd0, ay_reg} * {9'd0, ay_reg};
    assign sum_sq = sq_reg + ay_sq;

    // CORDIC step: floor shifts are arithmetic shifts.
    assign dx       = y_reg >>> step_reg;
    assign dy       = x_reg >>> step_reg;
    assign atan_val = goh_pkg::atan_phase(step_reg);

    // Square root step.
    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};

    // Clamp to the first octant, then unfold by octant and quadrant.
    always_comb begin
        if (zero_reg) begin
            oct = 32'd0;
        end else if (diag_reg) begin
            oct = goh_pkg::PHASE_OCTANT;
        end else if (z_reg[31]) begin
            oct = 32'd0;
        end else if (z_reg > $signed(goh_pkg::PHASE_OCTANT)) begin
            oct = goh_pkg::PHASE_OCTANT;
        end else begin
            oct = z_reg;
        end
        quad = swap_reg ? (goh_pkg::PHASE_QUARTER - oct) : oct;
        case ({gxn_reg, gyn_reg})
            2'b00:   phase_calc = quad;
            2'b10:   phase_calc = goh_pkg::PHASE_HALF - quad;
            2'b11:   phase_calc = goh_pkg::PHASE_HALF + quad;
            default: phase_calc = 32'd0 - quad;
        endcase
    end

    // Sequencer and datapath next values.
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        gxn_next   = gxn_reg;
        gyn_next   = gyn_reg;
        swap_next  = swap_reg;
        zero_next  = zero_reg;
        diag_next  = diag_reg;
        ay_next    = ay_reg;
        sq_next    = sq_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        done_next  = 1'b0;
        mag_next   = mag_reg;
        phase_next = phase_reg;
        case (state_reg)
            P_IDLE: begin
                if (req.start) begin
                    gxn_next   = req.grad_x[8];
                    gyn_next   = req.grad_y[8];
                    swap_next  = swap_in;
                    zero_next  = s_in == 9'd0;
                    diag_next  = s_in == l_in;
                    ay_next    = ay_in;
                    sq_next    = ax_sq;
                    x_next     = $signed({3'b000, l_in, 24'd0});
                    y_next     = $signed({3'b000, s_in, 24'd0});
                    z_next     = 32'sd0;
                    state_next = P_SQUARE;
                end
            end
            P_SQUARE: begin
                rem_next   = {1'b0, sum_sq, 4'd0};
                root_next  = 23'd0;
                bit_next   = 23'h40_0000;
                step_next  = 5'd0;
                state_next = P_ITER;
            end
            P_ITER: begin
                if (!y_reg[35]) begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + $signed(atan_val);
                end else begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - $signed(atan_val);
                end
                if (bit_reg != 23'd0) begin
                    if ({1'b0, rem_reg} >= trial) begin
                        rem_next  = rem_reg - trial[22:0];
                        root_next = (root_reg >> 1) + bit_reg;
                    end else begin
                        root_next = root_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(goh_pkg::CORDIC_STEPS - 1)) begin
                    state_next = P_FINAL;
                end
            end
            P_FINAL: begin
                mag_next   = goh_pkg::MAG_W'(root_reg)
                           + goh_pkg::MAG_W'(rem_reg > root_reg);
                phase_next = phase_calc;
                done_next  = 1'b1;
                state_next = P_IDLE;
            end
            default: begin
                state_next = P_IDLE;
            end
        endcase
    end

    // State and registered results.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= P_IDLE;
            step_reg  <= 5'd0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
        gxn_reg   <= gxn_next;
        gyn_reg   <= gyn_next;
        swap_reg  <= swap_next;
        zero_reg  <= zero_next;
        diag_reg  <= diag_next;
        ay_reg    <= ay_next;
        sq_reg    <= sq_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        bit_reg   <= bit_next;
        mag_reg   <= mag_next;
        phase_reg <= phase_next;
    end

    assign res.done      = done_reg;
    assign res.magnitude = mag_reg;
    assign res.phase     = phase_reg;

endmodule

`default_nettype wire

[design/gradient_orientation_histogram_unit.sv]
// Accumulate beat: the polar unit does squaring setup, 30 CORDIC steps and hand-off, then
// a read-modify-write of the bin memory. Read beat: a registered read of the bin memory.
// Clear beat: a sweep zeroes every bin. Each such beat then loads its result. One item is
// in work at a time; s_ready returns in the same cycle that the result is loaded, so a new
// beat waits for the last result to be loaded, and is taken while a result waits.
// Synchronous active-low reset clears control state, then a sweep zeroes all the bins.
// ----------------------------------------------------------------------------
// Gradient orientation histogram unit
// Converts gradients to magnitude and angle bin, accumulates magnitudes per
// bin with saturation, and serves bin reads and whole-histogram clears.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_orientation_histogram_unit #(
    parameter int BINS = 256
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output      logic                      s_ready,
    input  wire logic [1:0]                s_op,
    input  wire logic signed [8:0]         s_grad_x,
    input  wire logic signed [8:0]         s_grad_y,
    input  wire logic [7:0]                s_bin_index,
    output      logic                      m_valid,
    input  wire logic                      m_ready,
    output      logic [1:0]                m_item_kind,
    output      logic [goh_pkg::MAG_W-1:0] m_magnitude,
    output      logic [7:0]                m_angle_bin,
    output      logic [goh_pkg::SUM_W-1:0] m_bin_sum
);

    localparam int BIN_W  = $clog2(BINS);
    localparam int PROD_W = 32 + BIN_W;
    localparam int SUM_W  = goh_pkg::SUM_W;
    localparam int MAG_W  = goh_pkg::MAG_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POLAR,
        ST_BIN,
        ST_READ,
        ST_UPDATE
    } state_t;

    state_t             state_reg, state_next;
    logic [BIN_W-1:0]   addr_reg, addr_next;
    logic               clr_reply_reg, clr_reply_next;
    logic [1:0]         kind_reg, kind_next;
    logic               oor_reg, oor_next;
    logic [7:0]         ang_reg, ang_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic [31:0]        phase_reg, phase_next;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_item_kind_reg, m_item_kind_next;
    logic [MAG_W-1:0]   m_magnitude_reg, m_magnitude_next;
    logic [7:0]         m_angle_bin_reg, m_angle_bin_next;
    logic [SUM_W-1:0]   m_bin_sum_reg, m_bin_sum_next;

    logic [SUM_W-1:0]   mem [BINS];
    logic [SUM_W-1:0]   rdata_reg;
    logic               mem_we;
    logic [SUM_W-1:0]   mem_wdata;

    goh_pkg::polar_req_t pol_req;
    goh_pkg::polar_res_t pol_res;

    logic               accept;
    logic               out_free;
    logic               rd_oor;
    logic [PROD_W-1:0]  bin_prod;
    logic [BIN_W-1:0]   bin_calc;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_sat;

    // Handshake.
    assign s_ready  = state_reg == ST_IDLE;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Polar conversion starts on an accepted accumulate beat.
    assign pol_req.start  = accept && (s_op == goh_pkg::OP_ACCUM);
    assign pol_req.grad_x = s_grad_x;
    assign pol_req.grad_y = s_grad_y;

    goh_polar u_polar (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (pol_req),
        .res     (pol_res)
    );

    // Bin of the phase: floor(phase * BINS / 2^32).
    assign bin_prod = PROD_W'(phase_reg) * PROD_W'(BINS);
    assign bin_calc = bin_prod[PROD_W-1:32];

    // Reads beyond the histogram return zero.
    assign rd_oor = {24'd0, s_bin_index} >= 32'(BINS);

    // Saturating bin update.
    assign sum_wide = {1'b0, rdata_reg} + (SUM_W + 1)'(mag_reg);
    assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

    // Memory write: zero during the clear sweep, the new sum on update.
    assign mem_we    = (state_reg == ST_CLEAR)
                    || (state_reg == ST_UPDATE && out_free && kind_reg == goh_pkg::OP_ACCUM);
    assign mem_wdata = (state_reg == ST_CLEAR) ? {SUM_W{1'b0}} : sum_sat;

    // Sequencer and output register next values.
    always_comb begin
        state_next       = state_reg;
        addr_next        = addr_reg;
        clr_reply_next   = clr_reply_reg;
        kind_next        = kind_reg;
        oor_next         = oor_reg;
        ang_next         = ang_reg;
        mag_next         = mag_reg;
        phase_next       = phase_reg;
        m_valid_next     = m_ready ? 1'b0 : m_valid_reg;
        m_item_kind_next = m_item_kind_reg;
        m_magnitude_next = m_magnitude_reg;
        m_angle_bin_next = m_angle_bin_reg;
        m_bin_sum_next   = m_bin_sum_reg;
        case (state_reg)
            ST_CLEAR: begin
                addr_next = addr_reg + BIN_W'(1);
                if (addr_reg == BIN_W'(BINS - 1)) begin
                    addr_next = {BIN_W{1'b0}};
                    if (clr_reply_reg) begin
                        kind_next  = goh_pkg::OP_CLEAR;
                        state_next = ST_UPDATE;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (s_op)
                        goh_pkg::OP_ACCUM: begin
                            kind_next  = goh_pkg::OP_ACCUM;
                            oor_next   = 1'b0;
                            state_next = ST_POLAR;
                        end
                        goh_pkg::OP_READ: begin
                            kind_next  = goh_pkg::OP_READ;
                            oor_next   = rd_oor;
                            ang_next   = s_bin_index;
                            mag_next   = {MAG_W{1'b0}};
                            addr_next  = rd_oor ? {BIN_W{1'b0}} : BIN_W'(s_bin_index);
                            state_next = ST_READ;
                        end
                        goh_pkg::OP_CLEAR: begin
                            clr_reply_next = 1'b1;
                            addr_next      = {BIN_W{1'b0}};
                            state_next     = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_POLAR: begin
                if (pol_res.done) begin
                    mag_next   = pol_res.magnitude;
                    phase_next = pol_res.phase;
                    state_next = ST_BIN;
                end
            end
            ST_BIN: begin
                addr_next  = bin_calc;
                ang_next   = 8'(bin_calc);
                state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_item_kind_next = kind_reg;
                    case (kind_reg)
                        goh_pkg::OP_ACCUM: begin
                            m_magnitude_next = mag_reg;
                            m_angle_bin_next = ang_reg;
                            m_bin_sum_next   = sum_sat;
                        end
                        goh_pkg::OP_READ: begin
                            m_magnitude_next = {MAG_W{1'b0}};
                            m_angle_bin_next = ang_reg;
                            m_bin_sum_next   = oor_reg ? {SUM_W{1'b0}} : rdata_reg;
                        end
                        default: begin
                            m_magnitude_next = {MAG_W{1'b0}};
                            m_angle_bin_next = 8'd0;
                            m_bin_sum_next   = {SUM_W{1'b0}};
                        end
                    endcase
                    clr_reply_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= {BIN_W{1'b0}};
            clr_reply_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            clr_reply_reg <= clr_reply_next;
            m_valid_reg   <= m_valid_next;
        end
        kind_reg        <= kind_next;
        oor_reg         <= oor_next;
        ang_reg         <= ang_next;
        mag_reg         <= mag_next;
        phase_reg       <= phase_next;
        m_item_kind_reg <= m_item_kind_next;
        m_magnitude_reg <= m_magnitude_next;
        m_angle_bin_reg <= m_angle_bin_next;
        m_bin_sum_reg   <= m_bin_sum_next;
    end

    // Bin memory: one shared address, registered read data.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[addr_reg] <= mem_wdata;
        end
        rdata_reg <= mem[addr_reg];
    end

    assign m_valid     = m_valid_reg;
    assign m_item_kind = m_item_kind_reg;
    assign m_magnitude = m_magnitude_reg;
    assign m_angle_bin = m_angle_bin_reg;
    assign m_bin_sum   = m_bin_sum_reg;

    // An accumulate result carries a sum at least as large as its magnitude.
    a_accum_sum_covers_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item_kind == goh_pkg::OP_ACCUM) |-> (m_bin_sum >= SUM_W'(m_magnitude)))
        else $error("accumulate result sum below its magnitude");

    // A clear result carries only zero fields.
    a_clear_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item_kind == goh_pkg::OP_CLEAR)
        |-> (m_magnitude == '0 && m_angle_bin == 8'd0 && m_bin_sum == '0))
        else $error("clear result with nonzero fields");

    // A read beyond the histogram returns zero.
    a_read_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item_kind == goh_pkg::OP_READ && {24'd0, m_angle_bin} >= 32'(BINS))
        |-> (m_bin_sum == '0))
        else $error("out-of-range read returned a nonzero sum");

    // The polar unit only finishes while the sequencer waits for it.
    a_polar_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        pol_res.done |-> (state_reg == ST_POLAR))
        else $error("polar result arrived outside the wait state");

    // A new result is loaded only once the previous one has been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_bin_sum) && $stable(m_item_kind)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

[tb/sv/tb_gradient_orientation_histogram_unit.sv]
// ----------------------------------------------------------------------------
// Gradient orientation histogram unit testbench
// Sends accumulate, read, clear and unused-code beats under random idling on
// both channels. Result beats are checked field by field against typed table
// replies or a local polar conversion and bin store that follow each beat.
// ----------------------------------------------------------------------------
module tb_gradient_orientation_histogram_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAG_W = goh_pkg::MAG_W;
    localparam int SUM_W = goh_pkg::SUM_W;
    localparam int HIST_BINS = 256;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [SUM_W-1:0] SUM_CEILING = '1;
    localparam int RANDOM_BEATS = 1450;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = HIST_BINS + 64;

    // atan(2^-i) in turn units scaled by 2^32, rounded.
    localparam longint ARCTAN_STEP [goh_pkg::CORDIC_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680094, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
        5, 3, 1
    };

    typedef struct {
        logic [1:0]       kind;
        logic [MAG_W-1:0] magnitude;
        logic [7:0]       angle_bin;
        logic [SUM_W-1:0] bin_sum;
    } histogram_reply_t;

    typedef struct {
        logic [1:0]        op;
        logic signed [8:0] grad_x;
        logic signed [8:0] grad_y;
        logic [7:0]        bin_index;
        bit                typed;
        histogram_reply_t  reply;
    } stimulus_row_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [1:0]          s_op = goh_pkg::OP_ACCUM;
    logic signed [8:0]   s_grad_x = '0;
    logic signed [8:0]   s_grad_y = '0;
    logic [7:0]          s_bin_index = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [1:0]          m_item_kind;
    logic [MAG_W-1:0]    m_magnitude;
    logic [7:0]          m_angle_bin;
    logic [SUM_W-1:0]    m_bin_sum;

    logic [SUM_W-1:0]    bin_totals [HIST_BINS];
    histogram_reply_t    histogram_replies [$];
    stimulus_row_t       directed_rows [$];
    int                  mismatch_count = 0;
    int                  results_seen = 0;
    int                  stall_left = 0;
    int                  cycle_count = 0;
    int                  last_acc_bin = 0;

    gradient_orientation_histogram_unit #(
        .BINS(HIST_BINS)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_grad_x   (s_grad_x),
        .s_grad_y   (s_grad_y),
        .s_bin_index(s_bin_index),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item_kind(m_item_kind),
        .m_magnitude(m_magnitude),
        .m_angle_bin(m_angle_bin),
        .m_bin_sum  (m_bin_sum)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Round(4 * sqrt(gx^2 + gy^2)) by the bitwise integer square root.
    function automatic logic [MAG_W-1:0] quarter_magnitude(input int gx, input int gy);
        logic [31:0] radicand;
        logic [31:0] root;
        logic [31:0] rest;
        logic [31:0] probe;
        radicand = 32'(16 * (gx * gx + gy * gy));
        root = '0;
        rest = radicand;
        probe = 32'h4000_0000;
        while (probe > radicand) probe = probe >> 2;
        while (probe != 0) begin
            if (rest >= root + probe) begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        if (rest > root) root = root + 1;
        return root[MAG_W-1:0];
    endfunction

    // atan(s/l) in phase units for 0 <= s <= l, by CORDIC vectoring.
    function automatic logic [31:0] octant_angle(input longint s, input longint l);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        if (s == 0) return '0;
        if (s == l) return goh_pkg::PHASE_OCTANT;
        x = l <<< goh_pkg::CORDIC_PRESHIFT;
        y = s <<< goh_pkg::CORDIC_PRESHIFT;
        z = 0;
        for (int i = 0; i < goh_pkg::CORDIC_STEPS; i++) begin
            // Arithmetic shifts give floor division for negative values.
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_STEP[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_STEP[i];
            end
        end
        if (z < 0) z = 0;
        if (z > longint'(goh_pkg::PHASE_OCTANT)) z = longint'(goh_pkg::PHASE_OCTANT);
        return 32'(z);
    endfunction

    // Full-turn phase of the gradient: fold to one octant, then unfold.
    function automatic logic [31:0] gradient_phase(input int gx, input int gy);
        int          ax;
        int          ay;
        logic [31:0] q;
        ax = (gx < 0) ? -gx : gx;
        ay = (gy < 0) ? -gy : gy;
        if (ax == 0 && ay == 0) return '0;
        if (ay <= ax) q = octant_angle(ay, ax);
        else q = goh_pkg::PHASE_QUARTER - octant_angle(ax, ay);
        if (gx >= 0 && gy >= 0) return q;
        if (gx < 0 && gy >= 0) return goh_pkg::PHASE_HALF - q;
        if (gx < 0) return goh_pkg::PHASE_HALF + q;
        return 32'd0 - q;
    endfunction

    // Applies one accepted beat to the local bin store and gives its reply.
    function automatic bit histogram_step(input logic [1:0] op, input logic signed [8:0] gx,
                                          input logic signed [8:0] gy, input logic [7:0] idx,
                                          output histogram_reply_t reply);
        logic [63:0] scaled;
        logic [63:0] total;
        int          bin;
        reply = '{kind: op, magnitude: '0, angle_bin: '0, bin_sum: '0};
        case (op)
            goh_pkg::OP_ACCUM: begin
                reply.magnitude = quarter_magnitude(int'(gx), int'(gy));
                scaled = {32'd0, gradient_phase(int'(gx), int'(gy))} * 64'(HIST_BINS);
                bin = int'(scaled >> 32);
                if (bin >= HIST_BINS) bin = HIST_BINS - 1;
                total = 64'(bin_totals[bin]) + 64'(reply.magnitude);
                if (total > 64'(SUM_CEILING)) total = 64'(SUM_CEILING);
                bin_totals[bin] = total[SUM_W-1:0];
                reply.angle_bin = bin[7:0];
                reply.bin_sum = total[SUM_W-1:0];
                last_acc_bin = bin;
                return 1'b1;
            end
            goh_pkg::OP_READ: begin
                reply.angle_bin = idx;
                reply.bin_sum = (int'(idx) < HIST_BINS) ? bin_totals[idx] : '0;
                return 1'b1;
            end
            goh_pkg::OP_CLEAR: begin
                foreach (bin_totals[i]) bin_totals[i] = '0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void check_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endfunction

    // Gradient values weighted toward the extremes and small near-axis values.
    function automatic logic signed [8:0] pick_gradient();
        logic signed [8:0] corners [6];
        corners = '{-9'sd256, -9'sd255, -9'sd1, 9'sd0, 9'sd1, 9'sd255};
        case ($urandom_range(0, 7))
            0: return corners[$urandom_range(0, 5)];
            1: return 9'($signed($urandom_range(0, 6)) - 3);
            default: return 9'($urandom_range(0, 511));
        endcase
    endfunction

    task automatic add_row(input logic [1:0] op, input int gx, input int gy, input int idx,
                           input bit typed, input int kind = 0, input int mag = 0,
                           input int bin = 0, input longint sum = 0);
        stimulus_row_t row;
        row.op = op;
        row.grad_x = 9'(gx);
        row.grad_y = 9'(gy);
        row.bin_index = 8'(idx);
        row.typed = typed;
        row.reply = '{kind: 2'(kind), magnitude: MAG_W'(mag), angle_bin: 8'(bin),
                      bin_sum: SUM_W'(sum)};
        directed_rows.push_back(row);
    endtask

    // Presents one input beat after an optional gap and holds it until accepted.
    task automatic send_beat(input logic [1:0] op, input logic signed [8:0] gx,
                             input logic signed [8:0] gy, input logic [7:0] idx,
                             input int gap, input bit typed, input histogram_reply_t typed_reply);
        histogram_reply_t reply;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_grad_x <= gx;
        s_grad_y <= gy;
        s_bin_index <= idx;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (histogram_step(op, gx, gy, idx, reply))
            histogram_replies.push_back(typed ? typed_reply : reply);
    endtask

    // Result channel: check each beat against the oldest pending reply and
    // hold off ready for a random stall after most beats.
    always @(posedge aclk) begin : result_monitor
        histogram_reply_t want;
        int               stall;
        if (m_valid === 1'b1 && m_ready) begin
            if (histogram_replies.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: result beat with nothing pending, expected none, actual kind %0d",
                         $time, m_item_kind);
            end else begin
                want = histogram_replies.pop_front();
                check_field("item_kind", 64'(want.kind), 64'(m_item_kind));
                check_field("magnitude", 64'(want.magnitude), 64'(m_magnitude));
                check_field("angle_bin", 64'(want.angle_bin), 64'(m_angle_bin));
                check_field("bin_sum", 64'(want.bin_sum), 64'(m_bin_sum));
            end
            results_seen++;
            stall = (results_seen % 150 < 30) ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                m_ready <= 1'b0;
                stall_left = stall - 1;
            end
        end else if (!m_ready) begin
            if (stall_left == 0) m_ready <= 1'b1;
            else stall_left--;
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : stimulus
        histogram_reply_t  none;
        logic [1:0]        op;
        logic signed [8:0] gx;
        logic signed [8:0] gy;
        logic [7:0]        idx;
        int                gap;
        int                sent;
        int                pick;

        none = '{kind: '0, magnitude: '0, angle_bin: '0, bin_sum: '0};
        foreach (bin_totals[i]) bin_totals[i] = '0;

        // Directed table: empty store, axis and diagonal extremes, the
        // most negative encoding, the unused code, reads and a clear.
        add_row(goh_pkg::OP_READ, 0, 0, 0, 1, goh_pkg::OP_READ, 0, 0, 0);
        add_row(goh_pkg::OP_READ, 0, 0, 255, 1, goh_pkg::OP_READ, 0, 255, 0);
        add_row(goh_pkg::OP_ACCUM, 0, 0, 0, 1, goh_pkg::OP_ACCUM, 0, 0, 0);
        add_row(goh_pkg::OP_ACCUM, 255, 0, 0, 1, goh_pkg::OP_ACCUM, 1020, 0, 1020);
        add_row(goh_pkg::OP_ACCUM, 0, 255, 0, 1, goh_pkg::OP_ACCUM, 1020, 64, 1020);
        add_row(goh_pkg::OP_ACCUM, -255, 0, 0, 1, goh_pkg::OP_ACCUM, 1020, 128, 1020);
        add_row(goh_pkg::OP_ACCUM, 0, -255, 0, 1, goh_pkg::OP_ACCUM, 1020, 192, 1020);
        add_row(goh_pkg::OP_ACCUM, 255, 255, 0, 1, goh_pkg::OP_ACCUM, 1442, 32, 1442);
        add_row(goh_pkg::OP_ACCUM, -255, 255, 0, 1, goh_pkg::OP_ACCUM, 1442, 96, 1442);
        add_row(goh_pkg::OP_ACCUM, -256, -256, 0, 1, goh_pkg::OP_ACCUM, 1448, 160, 1448);
        add_row(goh_pkg::OP_ACCUM, 255, -255, 0, 1, goh_pkg::OP_ACCUM, 1442, 224, 1442);
        add_row(goh_pkg::OP_ACCUM, -256, 0, 0, 1, goh_pkg::OP_ACCUM, 1024, 128, 2044);
        add_row(OP_UNUSED, -1, -1, 255, 0);
        add_row(goh_pkg::OP_READ, 0, 0, 128, 1, goh_pkg::OP_READ, 0, 128, 2044);
        add_row(goh_pkg::OP_ACCUM, 1, 2, 0, 0);
        add_row(goh_pkg::OP_ACCUM, -3, 7, 0, 0);
        add_row(goh_pkg::OP_ACCUM, 100, -37, 0, 0);
        add_row(goh_pkg::OP_ACCUM, -1, -1, 0, 0);
        add_row(goh_pkg::OP_ACCUM, 255, 1, 0, 0);
        add_row(goh_pkg::OP_ACCUM, 1, -255, 0, 0);
        add_row(goh_pkg::OP_READ, 0, 0, 0, 0);
        add_row(goh_pkg::OP_CLEAR, 0, 0, 0, 1, goh_pkg::OP_CLEAR, 0, 0, 0);
        add_row(goh_pkg::OP_READ, 0, 0, 128, 1, goh_pkg::OP_READ, 0, 128, 0);
        add_row(goh_pkg::OP_READ, 0, 0, 32, 1, goh_pkg::OP_READ, 0, 32, 0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_beat(directed_rows[i].op, directed_rows[i].grad_x, directed_rows[i].grad_y,
                      directed_rows[i].bin_index, $urandom_range(0, 9),
                      directed_rows[i].typed, directed_rows[i].reply);

        // Random part: mostly accumulates, reads biased toward the bin just
        // filled, occasional clears and unused codes.
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) op = goh_pkg::OP_ACCUM;
            else if (pick < 93) op = goh_pkg::OP_READ;
            else if (pick < 96) op = goh_pkg::OP_CLEAR;
            else op = OP_UNUSED;
            gx = pick_gradient();
            gy = pick_gradient();
            if ($urandom_range(0, 9) == 0) gy = ($urandom_range(0, 1) != 0) ? gx : -gx;
            idx = 8'($urandom_range(0, 255));
            if (op == goh_pkg::OP_READ && $urandom_range(0, 1) != 0) idx = 8'(last_acc_bin);
            gap = (sent % 200 < 40) ? 0 : $urandom_range(0, 9);

            // Once midway, let the result side run dry before going on.
            if (sent == RANDOM_BEATS / 2 && op != OP_UNUSED) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (histogram_replies.size() != 0);
            end

            send_beat(op, gx, gy, idx, gap, 1'b0, none);
            if (op != OP_UNUSED) sent++;
        end
        s_valid <= 1'b0;

        while (histogram_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[filelist.f]
design/goh_pkg.sv
design/goh_polar.sv
design/gradient_orientation_histogram_unit.sv
tb/sv/tb_gradient_orientation_histogram_unit.sv
